// ===== hdl/assert_macros.svh =====
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, with a disable condition
`define SWF_ASSERT_IMP(name, clock, reset, ante, cons) \
  name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
    else $error("assertion violated");

// next-cycle implication, with a disable condition
`define SWF_ASSERT_NXT(name, clock, reset, ante, cons) \
  name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
    else $error("assertion violated");

`endif

// ===== hdl/swf_pkg.sv =====
// ---------------------------------------------------------------------------
// swf_pkg
// Shared widths, register codes, reset values and structs of the lidar
// wall-following steering block.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package swf_pkg;

  localparam int MAX_SCAN   = 2048;
  localparam int POS_W      = 12;
  localparam int SAMPLE_W   = 16;
  localparam int CROP_W     = 8;
  localparam int SPLIT_W    = 11;
  localparam int GAIN_W     = 12;
  localparam int ERR_W      = 18;
  localparam int ACC_W      = 32;
  localparam int STEER_W    = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 12;
  localparam int ROUND_SHIFT = 9;

  localparam logic signed [ACC_W-1:0] ROUND_BIAS = 32'sd256;
  localparam logic signed [ACC_W-1:0] STEER_MAX  = 32'sd32767;
  localparam logic signed [ACC_W-1:0] STEER_MIN  = -32'sd32768;

  localparam logic [POS_W-1:0]   RST_SCAN_LENGTH = 12'd1080;
  localparam logic [CROP_W-1:0]  RST_CROP_COUNT  = 8'd80;
  localparam logic [SPLIT_W-1:0] RST_SPLIT_INDEX = 11'd540;
  localparam logic [GAIN_W-1:0]  RST_PROP_GAIN   = 12'd333;
  localparam logic [GAIN_W-1:0]  RST_DERIV_GAIN  = 12'd51;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SCAN_LENGTH = 3'd0,
    CFG_CROP_COUNT  = 3'd1,
    CFG_SPLIT_INDEX = 3'd2,
    CFG_PROP_GAIN   = 3'd3,
    CFG_DERIV_GAIN  = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic [POS_W-1:0]          scan_length;
    logic [CROP_W-1:0]         crop_count;
    logic [SPLIT_W-1:0]        split_index;
    logic [GAIN_W-1:0]         proportional_gain;
    logic signed [GAIN_W-1:0]  derivative_gain;
  } cfg_t;

  typedef struct packed {
    logic signed [ERR_W-1:0] scan_error;
    logic signed [ERR_W-1:0] previous_error;
    logic                    on_left;
    logic [SAMPLE_W-1:0]     nearest;
  } final_t;

endpackage

`default_nettype wire

// ===== hdl/scan_wall_follow_pd_steer.sv =====
// ---------------------------------------------------------------------------
// scan_wall_follow_pd_steer
// Lidar wall-following PD steering.
//
// Range samples arrive one word per cycle on the input channel (in_valid,
// in_stall, range_sample) in scan order. Each scan of scan_length samples
// gives one word on the output channel (out_valid, out_stall,
// steering_value, nearest_range, nearest_on_left); other samples give none.
// Throughput is one sample per cycle while in_stall is low. The last
// sample of a scan sits in the input register, minimum tracking and the
// error load the final stage, then the PD multiply and saturate load the
// result register. While a result waits under out_stall, samples keep
// flowing; only a second finished scan backs up, and in_stall rises when
// the last sample of a scan finds the final stage full and the result
// register full under out_stall. Configuration must be written through
// cfg_write, cfg_index and cfg_data only while the block is idle; the
// block does not enforce this. Reset clears the scan state, the stored
// error and the pipeline, and loads the default register values.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module scan_wall_follow_pd_steer (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                cfg_write,
  input  wire logic [swf_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [swf_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire logic [swf_pkg::SAMPLE_W-1:0]        range_sample,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic signed [swf_pkg::STEER_W-1:0]       steering_value,
  output logic [swf_pkg::SAMPLE_W-1:0]             nearest_range,
  output logic                                     nearest_on_left
);

  swf_pkg::cfg_t   cfg;
  logic            fin_valid, fin_stall;
  swf_pkg::final_t fin;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.scan_length       <= swf_pkg::RST_SCAN_LENGTH;
      cfg.crop_count        <= swf_pkg::RST_CROP_COUNT;
      cfg.split_index       <= swf_pkg::RST_SPLIT_INDEX;
      cfg.proportional_gain <= swf_pkg::RST_PROP_GAIN;
      cfg.derivative_gain   <= swf_pkg::RST_DERIV_GAIN;
    end else if (cfg_write) begin
      case (swf_pkg::cfg_reg_t'(cfg_index))
        swf_pkg::CFG_SCAN_LENGTH: begin
          cfg.scan_length <= cfg_data[swf_pkg::POS_W-1:0];
        end
        swf_pkg::CFG_CROP_COUNT: begin
          cfg.crop_count <= cfg_data[swf_pkg::CROP_W-1:0];
        end
        swf_pkg::CFG_SPLIT_INDEX: begin
          cfg.split_index <= cfg_data[swf_pkg::SPLIT_W-1:0];
        end
        swf_pkg::CFG_PROP_GAIN: begin
          cfg.proportional_gain <= cfg_data[swf_pkg::GAIN_W-1:0];
        end
        swf_pkg::CFG_DERIV_GAIN: begin
          cfg.derivative_gain <= cfg_data[swf_pkg::GAIN_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  swf_track u_track (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .range_sample (range_sample),
    .fin_valid    (fin_valid),
    .fin_stall    (fin_stall),
    .fin          (fin)
  );

  swf_steer u_steer (
    .clk               (clk),
    .rst               (rst),
    .proportional_gain (cfg.proportional_gain),
    .derivative_gain   (cfg.derivative_gain),
    .fin_valid         (fin_valid),
    .fin_stall         (fin_stall),
    .fin               (fin),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .steering_value    (steering_value),
    .nearest_range     (nearest_range),
    .nearest_on_left   (nearest_on_left)
  );

endmodule

`default_nettype wire

// ===== hdl/swf_track.sv =====
// ---------------------------------------------------------------------------
// swf_track
// Input register and per-sample minimum tracking; at the end of a scan it
// forms the error and hands a final word to the steering stage.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module swf_track (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire swf_pkg::cfg_t                 cfg,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [swf_pkg::SAMPLE_W-1:0]  range_sample,
  output logic                               fin_valid,
  input  wire logic                          fin_stall,
  output swf_pkg::final_t                    fin
);

  logic                          s1_valid;
  logic [swf_pkg::SAMPLE_W-1:0]  s1_sample;

  logic [swf_pkg::POS_W-1:0]     pos;
  logic [swf_pkg::SAMPLE_W-1:0]  right_min, left_min, win_min;
  logic [swf_pkg::POS_W-1:0]     win_idx;
  logic                          right_loaded, left_loaded, win_loaded;
  logic signed [swf_pkg::ERR_W-1:0] prev_err;

  logic [swf_pkg::SAMPLE_W-1:0]  right_min_next, left_min_next, win_min_next;
  logic [swf_pkg::POS_W-1:0]     win_idx_next;
  logic                          right_loaded_next, left_loaded_next, win_loaded_next;

  logic [swf_pkg::POS_W-1:0]     len;
  logic [swf_pkg::POS_W:0]       pos_ext;
  logic                          in_window, is_right, last;
  logic [swf_pkg::CROP_W:0]      twice_crop;
  logic [swf_pkg::POS_W-1:0]     wlen;
  logic                          on_left;
  logic [swf_pkg::ERR_W:0]       err_wide;
  logic signed [swf_pkg::ERR_W-1:0] err;
  logic                          fin_ready, s1_fire;

  // effective scan length
  always_comb begin
    if (cfg.scan_length > swf_pkg::POS_W'(swf_pkg::MAX_SCAN)) begin
      len = swf_pkg::POS_W'(swf_pkg::MAX_SCAN);
    end else if (cfg.scan_length == '0) begin
      len = swf_pkg::POS_W'(1);
    end else begin
      len = cfg.scan_length;
    end
  end

  assign pos_ext   = {1'b0, pos};
  assign in_window = (pos >= swf_pkg::POS_W'(cfg.crop_count)) &&
                     ((pos_ext + (swf_pkg::POS_W+1)'(cfg.crop_count)) < {1'b0, len});
  assign is_right  = pos < swf_pkg::POS_W'(cfg.split_index);
  assign last      = (pos_ext + (swf_pkg::POS_W+1)'(1)) >= {1'b0, len};

  always_comb begin
    win_min_next      = win_min;
    win_idx_next      = win_idx;
    win_loaded_next   = win_loaded;
    right_min_next    = right_min;
    right_loaded_next = right_loaded;
    left_min_next     = left_min;
    left_loaded_next  = left_loaded;
    if (in_window) begin
      if (!win_loaded || s1_sample < win_min) begin
        win_min_next    = s1_sample;
        win_idx_next    = pos - swf_pkg::POS_W'(cfg.crop_count);
        win_loaded_next = 1'b1;
      end
      if (is_right) begin
        if (!right_loaded || s1_sample < right_min) begin
          right_min_next    = s1_sample;
          right_loaded_next = 1'b1;
        end
      end else begin
        if (!left_loaded || s1_sample < left_min) begin
          left_min_next    = s1_sample;
          left_loaded_next = 1'b1;
        end
      end
    end
  end

  // window length and side of the nearest return
  assign twice_crop = {cfg.crop_count, 1'b0};
  assign wlen = (len > swf_pkg::POS_W'(twice_crop)) ? len - swf_pkg::POS_W'(twice_crop) : '0;
  assign on_left = win_loaded_next && (win_idx_next > (wlen >> 1));

  // twice the error, exact
  assign err_wide = {2'b00, win_min_next, 1'b0}
                  - {3'b000, right_min_next}
                  - {3'b000, left_min_next};
  assign err = $signed(err_wide[swf_pkg::ERR_W-1:0]);

  assign fin_ready = !fin_valid || !fin_stall;
  assign s1_fire   = s1_valid && (!last || fin_ready);
  assign in_stall  = s1_valid && !s1_fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
    if (in_valid && !in_stall) begin
      s1_sample <= range_sample;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos          <= '0;
      right_min    <= '0;
      left_min     <= '0;
      win_min      <= '0;
      win_idx      <= '0;
      right_loaded <= 1'b0;
      left_loaded  <= 1'b0;
      win_loaded   <= 1'b0;
      prev_err     <= '0;
    end else if (s1_fire) begin
      if (last) begin
        pos          <= '0;
        right_min    <= '0;
        left_min     <= '0;
        win_min      <= '0;
        win_idx      <= '0;
        right_loaded <= 1'b0;
        left_loaded  <= 1'b0;
        win_loaded   <= 1'b0;
        prev_err     <= err;
      end else begin
        pos          <= pos + swf_pkg::POS_W'(1);
        right_min    <= right_min_next;
        left_min     <= left_min_next;
        win_min      <= win_min_next;
        win_idx      <= win_idx_next;
        right_loaded <= right_loaded_next;
        left_loaded  <= left_loaded_next;
        win_loaded   <= win_loaded_next;
      end
    end
  end

  // final word register
  always_ff @(posedge clk) begin
    if (rst) begin
      fin_valid <= 1'b0;
    end else if (fin_ready) begin
      fin_valid <= s1_fire && last;
    end
    if (fin_ready && s1_fire && last) begin
      fin.scan_error     <= err;
      fin.previous_error <= prev_err;
      fin.on_left        <= on_left;
      fin.nearest        <= win_min_next;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/swf_steer.sv =====
// ---------------------------------------------------------------------------
// swf_steer
// PD products, rounding and saturation of the steering command, with the
// result register on the output channel.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module swf_steer (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic [swf_pkg::GAIN_W-1:0]         proportional_gain,
  input  wire logic signed [swf_pkg::GAIN_W-1:0]  derivative_gain,
  input  wire logic                               fin_valid,
  output logic                                    fin_stall,
  input  wire swf_pkg::final_t                    fin,
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output logic signed [swf_pkg::STEER_W-1:0]      steering_value,
  output logic [swf_pkg::SAMPLE_W-1:0]            nearest_range,
  output logic                                    nearest_on_left
);

  logic signed [swf_pkg::GAIN_W:0]   kp;
  logic signed [swf_pkg::ERR_W:0]    err_diff;
  logic signed [swf_pkg::ACC_W-1:0]  p_prop, p_der, acc, q;
  logic signed [swf_pkg::STEER_W-1:0] steer;
  logic                               out_ready;

  assign kp = fin.on_left ? $signed({1'b0, proportional_gain})
                          : -$signed({1'b0, proportional_gain});
  assign err_diff = (swf_pkg::ERR_W+1)'(fin.previous_error)
                  - (swf_pkg::ERR_W+1)'(fin.scan_error);

  assign p_prop = swf_pkg::ACC_W'(kp) * swf_pkg::ACC_W'(fin.scan_error);
  assign p_der  = swf_pkg::ACC_W'(derivative_gain) * swf_pkg::ACC_W'(err_diff);
  assign acc    = p_prop + p_der + swf_pkg::ROUND_BIAS;
  assign q      = acc >>> swf_pkg::ROUND_SHIFT;

  always_comb begin
    if (q > swf_pkg::STEER_MAX) begin
      steer = swf_pkg::STEER_MAX[swf_pkg::STEER_W-1:0];
    end else if (q < swf_pkg::STEER_MIN) begin
      steer = swf_pkg::STEER_MIN[swf_pkg::STEER_W-1:0];
    end else begin
      steer = q[swf_pkg::STEER_W-1:0];
    end
  end

  assign out_ready = !out_valid || !out_stall;
  assign fin_stall = !out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_ready) begin
      out_valid <= fin_valid;
    end
    if (out_ready && fin_valid) begin
      steering_value  <= steer;
      nearest_range   <= fin.nearest;
      nearest_on_left <= fin.on_left;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/swf_checker.sv =====
// ---------------------------------------------------------------------------
// swf_checker
// Port-level checks of the steering block, bound to the top level.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module swf_checker (
  input wire logic                                clk,
  input wire logic                                rst,
  input wire logic                                in_stall,
  input wire logic                                out_valid,
  input wire logic                                out_stall,
  input wire logic signed [swf_pkg::STEER_W-1:0]  steering_value,
  input wire logic [swf_pkg::SAMPLE_W-1:0]        nearest_range,
  input wire logic                                nearest_on_left
);

  logic [swf_pkg::STEER_W+swf_pkg::SAMPLE_W:0] out_word;

  assign out_word = {steering_value, nearest_range, nearest_on_left};

  // a held result word keeps its value
  `SWF_ASSERT_NXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid && $stable(out_word))

  // the input only backs up behind a stalled result
  `SWF_ASSERT_IMP(a_stall_cause, clk, rst, in_stall, out_valid && out_stall)

  // reset empties the pipeline
  `SWF_ASSERT_NXT(a_reset_clear, clk, 1'b0, rst, !out_valid && !in_stall)

endmodule

bind scan_wall_follow_pd_steer swf_checker u_swf_checker (
  .clk             (clk),
  .rst             (rst),
  .in_stall        (in_stall),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .steering_value  (steering_value),
  .nearest_range   (nearest_range),
  .nearest_on_left (nearest_on_left)
);

`default_nettype wire

// ===== sim/scan_wall_follow_pd_steer_tb.sv =====
// ---------------------------------------------------------------------------
// scan_wall_follow_pd_steer_tb
// Self-checking bench for the lidar wall-following PD steering block.
//
// Range samples are streamed into the block with random gaps while the
// result side stalls at random. Every accepted sample is run through a
// behavioural model of the scan tracking and PD step held in the bench, and
// each finished scan leaves one expected result word in a queue. A checker
// compares every result word taken from the block, field by field, with the
// oldest expected word. The tests cover reset values, field extremes,
// saturation, empty windows and parts, odd scan lengths, register changes
// in the middle of a scan, a burst with no idling, and a long random run
// over many register settings.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module scan_wall_follow_pd_steer_tb;

  localparam int DRAIN_CYCLES = 8;
  localparam int STALL_LIMIT  = 4000;
  localparam int IDLE_PCT     = 17;

  typedef struct {
    logic signed [swf_pkg::STEER_W-1:0] steer;
    logic [swf_pkg::SAMPLE_W-1:0]       nearest;
    logic                               on_left;
  } steer_word_t;

  logic                               clk = 1'b0;
  logic                               rst = 1'b1;
  logic                               cfg_write = 1'b0;
  logic [swf_pkg::CFG_IDX_W-1:0]      cfg_index = swf_pkg::CFG_SCAN_LENGTH;
  logic [swf_pkg::CFG_DATA_W-1:0]     cfg_data = '0;
  logic                               in_valid = 1'b0;
  logic                               in_stall;
  logic [swf_pkg::SAMPLE_W-1:0]       range_sample = '0;
  logic                               out_valid;
  logic                               out_stall = 1'b0;
  logic signed [swf_pkg::STEER_W-1:0] steering_value;
  logic [swf_pkg::SAMPLE_W-1:0]       nearest_range;
  logic                               nearest_on_left;

  logic no_idle = 1'b0;
  int   error_count = 0;
  int   samples_sent = 0;
  int   idle_cycles = 0;
  logic [swf_pkg::SAMPLE_W-1:0] last_range = '0;

  steer_word_t pending_steer[$];

  // model state
  swf_pkg::cfg_t                    model_cfg;
  logic [swf_pkg::POS_W-1:0]        scan_pos;
  logic [swf_pkg::SAMPLE_W-1:0]     right_min, left_min, win_min;
  logic [swf_pkg::POS_W-1:0]        win_min_idx;
  logic                             right_seen, left_seen, win_seen;
  logic signed [swf_pkg::ERR_W-1:0] last_error;

  scan_wall_follow_pd_steer u_dut (
    .clk             (clk),
    .rst             (rst),
    .cfg_write       (cfg_write),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .range_sample    (range_sample),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .steering_value  (steering_value),
    .nearest_range   (nearest_range),
    .nearest_on_left (nearest_on_left)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic void clear_scan_model();
    scan_pos    = '0;
    right_min   = '0;
    left_min    = '0;
    win_min     = '0;
    win_min_idx = '0;
    right_seen  = 1'b0;
    left_seen   = 1'b0;
    win_seen    = 1'b0;
  endfunction

  function automatic void steer_model_step(input logic [swf_pkg::SAMPLE_W-1:0] x);
    int unsigned len, pos, wlen;
    int          e2, kp, kd;
    longint      acc, rounded;
    logic        on_left_e;
    steer_word_t w;
    len = model_cfg.scan_length;
    if (len > swf_pkg::MAX_SCAN) len = swf_pkg::MAX_SCAN;
    if (len == 0) len = 1;
    pos = scan_pos;
    if (pos >= model_cfg.crop_count && pos + model_cfg.crop_count < len) begin
      if (!win_seen || x < win_min) begin
        win_min     = x;
        win_min_idx = swf_pkg::POS_W'(pos - model_cfg.crop_count);
        win_seen    = 1'b1;
      end
      if (pos < model_cfg.split_index) begin
        if (!right_seen || x < right_min) begin
          right_min  = x;
          right_seen = 1'b1;
        end
      end else begin
        if (!left_seen || x < left_min) begin
          left_min  = x;
          left_seen = 1'b1;
        end
      end
    end
    if (pos + 1 < len) begin
      scan_pos = swf_pkg::POS_W'(pos + 1);
      return;
    end
    wlen = (len > 2 * model_cfg.crop_count) ? len - 2 * model_cfg.crop_count : 0;
    on_left_e = win_seen && (win_min_idx > wlen / 2);
    e2 = 2 * int'(win_min) - int'(right_min) - int'(left_min);
    kp = on_left_e ? int'(model_cfg.proportional_gain) : -int'(model_cfg.proportional_gain);
    kd = int'($signed(model_cfg.derivative_gain));
    acc = longint'(kp) * e2 + longint'(kd) * (longint'(last_error) - e2);
    rounded = (acc + 256) >>> swf_pkg::ROUND_SHIFT;
    if (rounded > 32767) rounded = 32767;
    if (rounded < -32768) rounded = -32768;
    w.steer   = swf_pkg::STEER_W'(rounded);
    w.nearest = win_min;
    w.on_left = on_left_e;
    pending_steer.push_back(w);
    last_error = swf_pkg::ERR_W'(e2);
    clear_scan_model();
  endfunction

  function automatic logic [swf_pkg::SAMPLE_W-1:0] pick_range();
    case ($urandom_range(7))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return swf_pkg::SAMPLE_W'($urandom_range(31));
      3: return last_range;
      default: return swf_pkg::SAMPLE_W'($urandom);
    endcase
  endfunction

  task automatic send_sample(input logic [swf_pkg::SAMPLE_W-1:0] x);
    while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    range_sample <= x;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    steer_model_step(x);
    last_range = x;
    samples_sent++;
  endtask

  task automatic send_scan(input int count);
    repeat (count) send_sample(pick_range());
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_steer.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // holds cfg_write high; end_writes lowers it
  task automatic write_reg(input swf_pkg::cfg_reg_t idx,
                           input logic [swf_pkg::CFG_DATA_W-1:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    case (idx)
      swf_pkg::CFG_SCAN_LENGTH: model_cfg.scan_length       = val;
      swf_pkg::CFG_CROP_COUNT:  model_cfg.crop_count        = val[swf_pkg::CROP_W-1:0];
      swf_pkg::CFG_SPLIT_INDEX: model_cfg.split_index       = val[swf_pkg::SPLIT_W-1:0];
      swf_pkg::CFG_PROP_GAIN:   model_cfg.proportional_gain = val;
      swf_pkg::CFG_DERIV_GAIN:  model_cfg.derivative_gain   = val;
      default: ;
    endcase
  endtask

  task automatic end_writes();
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  task automatic configure(input logic [11:0] len, input logic [11:0] crop,
                           input logic [11:0] split, input logic [11:0] kp,
                           input logic [11:0] kd);
    write_reg(swf_pkg::CFG_SCAN_LENGTH, len);
    write_reg(swf_pkg::CFG_CROP_COUNT, crop);
    write_reg(swf_pkg::CFG_SPLIT_INDEX, split);
    write_reg(swf_pkg::CFG_PROP_GAIN, kp);
    write_reg(swf_pkg::CFG_DERIV_GAIN, kd);
    end_writes();
  endtask

  // reset gains, crop and split; only the length is shortened
  task automatic test_reset_defaults();
    write_reg(swf_pkg::CFG_SCAN_LENGTH, 12'd164);
    end_writes();
    send_scan(164);
    drain();
  endtask

  task automatic test_extremes();
    configure(12'd4, 12'd0, 12'd2, 12'd4095, 12'h800);
    send_sample(16'h0000); send_sample(16'hFFFF);
    send_sample(16'hFFFF); send_sample(16'hFFFF);
    send_sample(16'hFFFF); send_sample(16'hFFFF);
    send_sample(16'hFFFF); send_sample(16'h0000);
    drain();
    configure(12'd4, 12'd0, 12'd2, 12'd0, 12'h7FF);
    send_sample(16'd1); send_sample(16'd2); send_sample(16'd3); send_sample(16'd4);
    // ties keep the first minimum
    send_sample(16'd7); send_sample(16'd7); send_sample(16'd7); send_sample(16'd7);
    drain();
    // window cropped away
    configure(12'd4, 12'd2, 12'd2, 12'd2730, 12'h555);
    send_scan(4);
    drain();
    // split past the window, then at the window start
    configure(12'd4, 12'd0, 12'd2047, 12'd1365, 12'hAAA);
    send_scan(4);
    drain();
    configure(12'd6, 12'd1, 12'd1, 12'd4095, 12'h001);
    send_scan(6);
    drain();
  endtask

  task automatic test_length_corners();
    // zero acts as a length of one
    configure(12'd0, 12'd0, 12'd1, 12'd256, 12'hF00);
    send_scan(2);
    drain();
    // oversize length, then a shorter one with the position already past it
    configure(12'd4095, 12'd0, 12'd2047, 12'd300, 12'd100);
    send_scan(3);
    drain();
    write_reg(swf_pkg::CFG_SCAN_LENGTH, 12'd2);
    end_writes();
    send_scan(1);
    drain();
  endtask

  task automatic test_burst();
    no_idle <= 1'b1;
    configure(12'd8, 12'd1, 12'd4, 12'($urandom_range(4095)), 12'($urandom_range(4095)));
    send_scan(48);
    drain();
    no_idle <= 1'b0;
  endtask

  task automatic test_random();
    int rand_items;
    int len, eff, crop, split;
    rand_items = samples_sent;
    while (samples_sent - rand_items < 300) begin
      case ($urandom_range(15))
        0: len = $urandom_range(3);
        1: len = $urandom_range(33, 96);
        default: len = $urandom_range(4, 24);
      endcase
      eff   = (len == 0) ? 1 : len;
      crop  = ($urandom_range(7) == 0) ? $urandom_range(255) : $urandom_range(eff / 2);
      split = ($urandom_range(7) == 0) ? $urandom_range(1, 2047) : $urandom_range(eff);
      configure(12'(len), 12'(crop), 12'(split), 12'($urandom_range(4095)),
                12'($urandom_range(4095)));
      repeat ($urandom_range(1, 4)) send_scan(eff);
      // broken scan: the next settings land mid-scan
      if ($urandom_range(3) == 0) send_scan($urandom_range(eff - 1));
      drain();
    end
  endtask

  always @(posedge clk) begin
    if (rst) out_stall <= 1'b0;
    else out_stall <= !no_idle && ($urandom_range(99) < IDLE_PCT);
  end

  always @(posedge clk) begin
    steer_word_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_steer.size() == 0) begin
        error_count++;
        $display("%0t: unexpected word steer %0d nearest %0d left %0b", $time,
                 steering_value, nearest_range, nearest_on_left);
      end else begin
        want = pending_steer.pop_front();
        if (steering_value !== want.steer) begin
          error_count++;
          $display("%0t: steering_value expected %0d actual %0d", $time, want.steer,
                   steering_value);
        end
        if (nearest_range !== want.nearest) begin
          error_count++;
          $display("%0t: nearest_range expected %0d actual %0d", $time, want.nearest,
                   nearest_range);
        end
        if (nearest_on_left !== want.on_left) begin
          error_count++;
          $display("%0t: nearest_on_left expected %0b actual %0b", $time, want.on_left,
                   nearest_on_left);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("%0t: watchdog, no progress for %0d cycles", $time, idle_cycles);
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    model_cfg.scan_length       = swf_pkg::RST_SCAN_LENGTH;
    model_cfg.crop_count        = swf_pkg::RST_CROP_COUNT;
    model_cfg.split_index       = swf_pkg::RST_SPLIT_INDEX;
    model_cfg.proportional_gain = swf_pkg::RST_PROP_GAIN;
    model_cfg.derivative_gain   = swf_pkg::RST_DERIV_GAIN;
    last_error = '0;
    clear_scan_model();
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_defaults();
    test_extremes();
    test_length_corners();
    test_burst();
    test_random();
    drain();
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
